FILE: rtl/planar_odometry_integrator_macros.svh
// Assertion macros used by the odometry integrator checker.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_MACROS_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define POI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define POI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check what a reset cycle leaves behind.
`define POI_ASSERT_AFTER_RESET(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

FILE: rtl/poi_pkg.sv
package poi_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int POSITION_BITS_DEF = 32;

    // Pipeline depth: input, four sine polynomial steps, multiply, accumulate
    localparam int PIPE_STAGES = 7;

    // Quarter wave polynomial coefficients, Q14
    localparam logic [14:0] TRIG_A = 15'd25736;
    localparam logic [13:0] TRIG_B = 14'd10512;
    localparam logic [10:0] TRIG_C = 11'd1160;

    localparam logic [14:0] Q14_ONE      = 15'd16384;
    localparam logic [15:0] PHASE_QUARTER = 16'd16384;

    typedef struct packed {
        logic signed [31:0] odometer_distance;
        logic        [15:0] bearing;
        logic signed [15:0] trans_speed;
        logic signed [15:0] rot_speed;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [15:0] heading;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] yaw_rate;
        logic        [15:0] raw_bearing;
    } t_out_item;

endpackage

FILE: rtl/planar_odometry_integrator.sv
// Planar dead-reckoning integrator. Each accepted odometry item yields one result item,
// in order. The first item after reset sets the heading origin and a zero pose; later
// items add the distance delta resolved through the previous heading to x and y
// (saturating) and advance the heading by the raw bearing delta; velocity is resolved
// through the new heading. The block is a seven-register pipeline and accepts one item
// every cycle while the output is not stalled. The stages are the input register, the
// sine/cosine polynomial (four dependent multiplies, each followed by a register), one
// multiply stage and one accumulate stage. The input stalls only when every stage
// holds an item and the output is stalled.
module planar_odometry_integrator #(
    parameter int ANGLE_BITS    = poi_pkg::ANGLE_BITS_DEF,
    parameter int POSITION_BITS = poi_pkg::POSITION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  poi_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output poi_pkg::t_out_item o_out_item
);
    import poi_pkg::*;

    localparam int NS = PIPE_STAGES;
    localparam int SW = ((POSITION_BITS > 34) ? POSITION_BITS : 34) + 1;
    localparam int OW = (POSITION_BITS > 32) ? POSITION_BITS : 32;

    typedef struct packed {
        logic               first;
        logic signed [31:0] dd;
        logic signed [15:0] tspeed;
        logic signed [15:0] rot;
        logic        [15:0] brg_raw;
        logic        [15:0] heading;
        logic        [15:0] phase;
    } t_carry;

    // handshake
    logic [NS-1:0] r_vld;
    logic [NS-1:0] ready;
    logic          accept;

    // state updated at acceptance
    logic                  r_started;
    logic [ANGLE_BITS-1:0] r_heading;
    logic [ANGLE_BITS-1:0] r_prev_brg;
    logic signed [31:0]    r_prev_dist;
    logic [ANGLE_BITS-1:0] brg;
    logic [ANGLE_BITS-1:0] n_heading;
    logic [15:0]           n_phase;
    t_carry                n_carry;

    t_carry r_carry [NS-1];

    // trig lanes: 0 is cosine, 1 is sine
    logic [15:0] lane_ph  [2];
    logic [14:0] z0       [2];
    logic [29:0] zz       [2];
    logic [14:0] r_z1     [2];
    logic [14:0] r_zsq1   [2];
    logic        r_neg1   [2];
    logic [25:0] c_prod   [2];
    logic [13:0] r_tb2    [2];
    logic [14:0] r_zsq2   [2];
    logic [14:0] r_z2     [2];
    logic        r_neg2   [2];
    logic [28:0] b_prod   [2];
    logic [14:0] r_ta3    [2];
    logic [14:0] r_z3     [2];
    logic        r_neg3   [2];
    logic [29:0] a_prod   [2];
    logic signed [15:0] r_trig4 [2];

    // velocity and position delta
    logic signed [15:0] r_last_trig [2];
    logic signed [31:0] prod_v      [2];
    logic signed [31:0] rnd_v       [2];
    logic signed [15:0] vel         [2];
    logic signed [47:0] prod_p      [2];
    logic signed [47:0] rnd_p       [2];
    logic signed [15:0] r_vel5      [2];
    logic signed [33:0] r_dpos5     [2];

    // accumulation
    logic signed [POSITION_BITS-1:0] r_acc   [2];
    logic signed [SW-1:0]            sum     [2];
    logic signed [POSITION_BITS-1:0] acc_nxt [2];
    logic signed [OW-1:0]            pos_ext [2];
    logic [SW-POSITION_BITS:0]       hi      [2];
    t_out_item                       r_out;

    // ---------------- handshake ----------------
    assign ready[NS-1] = !r_vld[NS-1] || !i_out_stall;
    for (genvar k = 0; k < NS - 1; k++) begin : g_ready
        assign ready[k] = !r_vld[k] || ready[k+1];
    end

    assign accept     = i_in_valid && ready[0];
    assign o_in_stall = !ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ready[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (ready[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- acceptance: heading and distance delta ----------------
    always_comb begin
        brg       = ANGLE_BITS'(i_in_item.bearing);
        n_heading = r_started ? ANGLE_BITS'(r_heading + (brg - r_prev_brg)) : '0;
    end

    if (ANGLE_BITS >= 16) begin : g_ph_hi
        assign n_phase = 16'(n_heading >> (ANGLE_BITS - 16));
    end else begin : g_ph_lo
        assign n_phase = 16'(n_heading) << (16 - ANGLE_BITS);
    end

    always_comb begin
        n_carry.first   = !r_started;
        n_carry.dd      = i_in_item.odometer_distance - r_prev_dist;
        n_carry.tspeed  = i_in_item.trans_speed;
        n_carry.rot     = i_in_item.rot_speed;
        n_carry.brg_raw = i_in_item.bearing;
        n_carry.heading = 16'(n_heading);
        n_carry.phase   = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_heading   <= '0;
            r_prev_brg  <= '0;
            r_prev_dist <= '0;
        end else if (accept) begin
            r_started   <= 1'b1;
            r_heading   <= n_heading;
            r_prev_brg  <= brg;
            r_prev_dist <= i_in_item.odometer_distance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready[0]) begin
            r_carry[0] <= n_carry;
        end
        for (int k = 1; k < NS - 1; k++) begin
            if (ready[k]) begin
                r_carry[k] <= r_carry[k-1];
            end
        end
    end

    // ---------------- sine / cosine polynomial ----------------
    always_comb begin
        lane_ph[0] = r_carry[0].phase + PHASE_QUARTER;
        lane_ph[1] = r_carry[0].phase;
        for (int l = 0; l < 2; l++) begin
            // fold into the first quadrant
            z0[l]     = lane_ph[l][14] ? Q14_ONE - {1'b0, lane_ph[l][13:0]}
                                       : {1'b0, lane_ph[l][13:0]};
            zz[l]     = z0[l] * z0[l];
            c_prod[l] = TRIG_C * r_zsq1[l];
            b_prod[l] = r_tb2[l] * r_zsq2[l];
            a_prod[l] = r_ta3[l] * r_z3[l];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            if (ready[1]) begin
                r_z1[l]   <= z0[l];
                r_zsq1[l] <= zz[l][28:14];
                r_neg1[l] <= lane_ph[l][15];
            end
            if (ready[2]) begin
                r_tb2[l]  <= TRIG_B - {2'b00, c_prod[l][25:14]};
                r_zsq2[l] <= r_zsq1[l];
                r_z2[l]   <= r_z1[l];
                r_neg2[l] <= r_neg1[l];
            end
            if (ready[3]) begin
                r_ta3[l]  <= TRIG_A - b_prod[l][28:14];
                r_z3[l]   <= r_z2[l];
                r_neg3[l] <= r_neg2[l];
            end
            if (ready[4]) begin
                r_trig4[l] <= r_neg3[l] ? -$signed(a_prod[l][29:14])
                                        : $signed(a_prod[l][29:14]);
            end
        end
    end

    // ---------------- velocity and position delta ----------------
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            prod_v[l] = $signed(r_carry[4].tspeed) * r_trig4[l];
            rnd_v[l]  = (prod_v[l] + 32'sd8192) >>> 14;
            if (rnd_v[l] > 32'sd32767) begin
                vel[l] = 16'sh7FFF;
            end else if (rnd_v[l] < -32'sd32768) begin
                vel[l] = -16'sh8000;
            end else begin
                vel[l] = rnd_v[l][15:0];
            end
            // distance moves along the heading of the item ahead
            prod_p[l] = $signed(r_carry[4].dd) * r_last_trig[l];
            rnd_p[l]  = (prod_p[l] + 48'sd8192) >>> 14;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            if (ready[5]) begin
                r_vel5[l]  <= vel[l];
                r_dpos5[l] <= rnd_p[l][33:0];
            end
            if (ready[5] && r_vld[4]) begin
                r_last_trig[l] <= r_trig4[l];
            end
        end
    end

    // ---------------- accumulate with saturation ----------------
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            sum[l] = SW'(r_acc[l]) + SW'(r_dpos5[l]);
            hi[l]  = sum[l][SW-1:POSITION_BITS-1];
            if (r_carry[5].first) begin
                acc_nxt[l] = '0;
            end else if ((&hi[l]) || !(|hi[l])) begin
                acc_nxt[l] = sum[l][POSITION_BITS-1:0];
            end else if (sum[l][SW-1]) begin
                acc_nxt[l] = {1'b1, {(POSITION_BITS-1){1'b0}}};
            end else begin
                acc_nxt[l] = {1'b0, {(POSITION_BITS-1){1'b1}}};
            end
            pos_ext[l] = OW'(acc_nxt[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready[6] && r_vld[5]) begin
            r_acc[0] <= acc_nxt[0];
            r_acc[1] <= acc_nxt[1];
        end
        if (ready[6]) begin
            r_out.pos_x       <= pos_ext[0][31:0];
            r_out.pos_y       <= pos_ext[1][31:0];
            r_out.heading     <= r_carry[5].heading;
            r_out.vel_x       <= r_vel5[0];
            r_out.vel_y       <= r_vel5[1];
            r_out.yaw_rate    <= r_carry[5].rot;
            r_out.raw_bearing <= r_carry[5].brg_raw;
        end
    end

    assign o_out_valid = r_vld[NS-1];
    assign o_out_item  = r_out;

endmodule

FILE: rtl/poi_checker.sv
`include "planar_odometry_integrator_macros.svh"

module poi_checker #(
    parameter int ANGLE_BITS = poi_pkg::ANGLE_BITS_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input poi_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input poi_pkg::t_out_item o_out_item
);
    import poi_pkg::*;

    `POI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item), "stalled result item changed")

    `POI_ASSERT_AFTER_RESET(a_reset_empty, i_clk, i_rst_n, !o_out_valid, "result valid right after reset")

    `POI_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stalled while output can drain")

    `POI_ASSERT_NOW(a_zero_heading, i_clk, i_rst_n, o_out_valid && (ANGLE_BITS <= 16) && (o_out_item.heading == 16'd0), o_out_item.vel_y == 16'sd0, "sideways velocity at zero heading")

    `POI_ASSERT_NOW(a_quarter_heading, i_clk, i_rst_n, o_out_valid && (ANGLE_BITS == 16) && (o_out_item.heading == 16'd16384), o_out_item.vel_x == 16'sd0, "forward velocity at quarter turn")

endmodule

bind planar_odometry_integrator poi_checker #(.ANGLE_BITS(ANGLE_BITS)) u_poi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
